// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// checked outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/dimp_pkg.sv =====
// ----------------------------------------------------------------------------
// dimp_pkg
// Shared widths, constants and types of the damped item-mean predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package dimp_pkg;

   // table depth default
   localparam int MAX_ITEMS_DEF = 4096;

   // field widths
   localparam int USER_W      = 20;
   localparam int ITEM_W      = 12;
   localparam int RATING_W    = 11;
   localparam int SCORE_W     = 11;
   localparam int SUM_W       = 32;
   localparam int CNT_W       = 20;
   localparam int NUM_USERS_W = 21;
   localparam int NUM_ITEMS_W = 13;

   // stream widths
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;

   // configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 21;
   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_USERS   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_ITEMS   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MEAN_RATING = 2'd2;

   // request kinds
   localparam logic FUNC_ADD     = 1'b0;
   localparam logic FUNC_PREDICT = 1'b1;

   // scoring constants
   localparam int PRIOR_COUNT = 5;
   localparam int SCORE_MIN   = 128;
   localparam int SCORE_MAX   = 1280;

   // divider widths
   localparam int DIVIDEND_W = SUM_W;
   localparam int DIVISOR_W  = CNT_W + 1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_DIV,
      ST_WRITE
   } dimp_state_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } dimp_div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } dimp_div_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/dimp_div.sv =====
// ----------------------------------------------------------------------------
// dimp_div
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dimp_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire dimp_pkg::dimp_div_req_type div_req,
   output dimp_pkg::dimp_div_rsp_type      div_rsp
);

   localparam int DVD_W  = dimp_pkg::DIVIDEND_W;
   localparam int DVS_W  = dimp_pkg::DIVISOR_W;
   localparam int STEP_W = $clog2(DVD_W + 1);

   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  dsr_ff, dsr_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              done_ff, done_in;

   logic [DVS_W:0]    shifted;
   logic [DVS_W+1:0]  diff;
   logic              fits;

   // one trial subtraction per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[DVD_W-1]};
      diff    = {1'b0, shifted} - {2'b00, dsr_ff};
      fits    = ~diff[DVS_W+1];
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
         step_in = STEP_W'(DVD_W);
      end else if (step_ff != '0) begin
         rem_in  = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
         quo_in  = {quo_ff[DVD_W-2:0], fits};
         step_in = step_ff - 1'b1;
         done_in = (step_ff == STEP_W'(1));
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/damped_item_mean_predictor_top.sv =====
// ----------------------------------------------------------------------------
// damped_item_mean_predictor_top
// Per-item damped mean rating: sum/count table, bit-serial score update.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request per transfer. req_tuser selects add (0) or
//   predict (1); req_tdata holds user_id, item_id and rating_value.
//   rsp_* returns one score for each predict request, none for adds.
//   csr_* writes num_users, num_items and the global mean; writing num_items
//   or the global mean clears the sum and count table.
// Sequence:
//   Predict: idle takes the transfer, the row is read, evaluate loads the
//   score into the output register, then idle takes the next request.
//   Add (valid ids): table read and evaluate, the 32-step bit-serial divider
//   plus its done strobe, write-back, and the idle state that takes the next
//   transfer.
//   Add (invalid ids): table read and evaluate, then back to idle.
// Reset and clearing:
//   After reset, and after a clearing write, the table is swept one entry
//   per cycle over all MAX_ITEMS entries; req_tready stays low meanwhile.
// Stall:
//   A result waits in the output register; adds go on, but a second predict
//   is held in evaluate, with no request taken, until the waiting result is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module damped_item_mean_predictor_top #(
   parameter int MAX_ITEMS = dimp_pkg::MAX_ITEMS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // config write port
   input  wire logic                                csr_we,
   input  wire logic [dimp_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire logic [dimp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // request stream
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // tdata: user_id[19:0], item_id[31:20], rating_value[42:32], zero pad
   input  wire logic [dimp_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: func
   input  wire logic                                req_tuser,
   // response stream
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // tdata: score[10:0], zero pad
   output logic [dimp_pkg::RSP_DATA_W-1:0]          rsp_tdata
);

   localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int LIM_W  = ($clog2(MAX_ITEMS + 1) > dimp_pkg::NUM_ITEMS_W) ?
                           $clog2(MAX_ITEMS + 1) : dimp_pkg::NUM_ITEMS_W;
   localparam int USER_W = dimp_pkg::USER_W;
   localparam int ITEM_W = dimp_pkg::ITEM_W;
   localparam int RAT_W  = dimp_pkg::RATING_W;
   localparam int SC_W   = dimp_pkg::SCORE_W;
   localparam int SUM_W  = dimp_pkg::SUM_W;
   localparam int CNT_W  = dimp_pkg::CNT_W;
   localparam int DVS_W  = dimp_pkg::DIVISOR_W;
   localparam int S_W    = SUM_W + 2;

   typedef struct packed {
      logic [SC_W-1:0]  score;
      logic [CNT_W-1:0] count;
      logic [SUM_W-1:0] sum;
   } row_type;

   // state and config registers
   dimp_pkg::dimp_state_type state_ff, state_in;
   logic [ADDR_W-1:0]                  clr_cnt_ff, clr_cnt_in;
   logic [dimp_pkg::NUM_USERS_W-1:0]   num_users_ff;
   logic [dimp_pkg::NUM_ITEMS_W-1:0]   num_items_ff;
   logic [RAT_W-1:0]                   mean_ff;

   // per-request registers
   logic              func_ff;
   logic              ids_ok_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [RAT_W-1:0]  rating_ff;
   row_type           rd_row_ff;
   logic [SUM_W-1:0]  sum_new_ff;
   logic [CNT_W-1:0]  cnt_new_ff;
   logic              neg_ff;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SC_W-1:0]  score_ff;

   // table
   row_type mem [MAX_ITEMS];
   row_type mem_wdata;
   logic [ADDR_W-1:0] mem_waddr;

   // control outputs
   logic req_acc, clr_start, clr_last, out_free;
   logic mem_we, div_start, rsp_load, upd_latch;
   logic add_go;

   // datapath
   logic [USER_W-1:0]      req_user;
   logic [ITEM_W-1:0]      req_item;
   logic [RAT_W-1:0]       req_rating;
   logic [ADDR_W+ITEM_W-1:0] item_ext;
   logic [LIM_W-1:0]       item_cmp, lim;
   logic                   ids_ok;
   logic signed [RAT_W:0]  dev;
   logic [SUM_W:0]         sum_wide;
   logic [SUM_W-1:0]       sum_sat;
   logic [CNT_W-1:0]       cnt_sat;
   logic [DVS_W-1:0]       divisor;
   logic [SUM_W-1:0]       dividend;
   logic [SC_W-1:0]        pred_score;
   logic [S_W-1:0]         q_mag, q_sgn, s_wide;
   logic [SC_W-1:0]        new_score;

   dimp_pkg::dimp_div_req_type div_req;
   dimp_pkg::dimp_div_rsp_type div_rsp;

   assign req_user   = req_tdata[USER_W-1:0];
   assign req_item   = req_tdata[USER_W+ITEM_W-1:USER_W];
   assign req_rating = req_tdata[USER_W+ITEM_W+RAT_W-1:USER_W+ITEM_W];

   assign req_acc   = req_tvalid & req_tready;
   assign clr_start = csr_we & ((csr_addr == dimp_pkg::CSR_NUM_ITEMS) ||
                                (csr_addr == dimp_pkg::CSR_MEAN_RATING));
   assign clr_last  = (clr_cnt_ff == ADDR_W'(MAX_ITEMS - 1));
   assign out_free  = ~rsp_valid_ff | rsp_tready;
   assign add_go    = (func_ff == dimp_pkg::FUNC_ADD) & ids_ok_ff;

   // id check against config, table depth caps num_items
   always_comb begin
      item_ext = {{ADDR_W{1'b0}}, req_item};
      item_cmp = LIM_W'(req_item);
      lim      = (LIM_W'(num_items_ff) > LIM_W'(MAX_ITEMS)) ?
                 LIM_W'(MAX_ITEMS) : LIM_W'(num_items_ff);
      ids_ok   = ({1'b0, req_user} < num_users_ff) && (item_cmp < lim);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dimp_pkg::ST_CLEAR: if (clr_last) state_in = dimp_pkg::ST_IDLE;
         dimp_pkg::ST_IDLE:  if (req_acc) state_in = dimp_pkg::ST_READ;
         dimp_pkg::ST_READ:  state_in = dimp_pkg::ST_EVAL;
         dimp_pkg::ST_EVAL: begin
            if (func_ff == dimp_pkg::FUNC_PREDICT) begin
               if (out_free) state_in = dimp_pkg::ST_IDLE;
            end else if (ids_ok_ff) begin
               state_in = dimp_pkg::ST_DIV;
            end else begin
               state_in = dimp_pkg::ST_IDLE;
            end
         end
         dimp_pkg::ST_DIV:   if (div_rsp.done) state_in = dimp_pkg::ST_WRITE;
         dimp_pkg::ST_WRITE: state_in = dimp_pkg::ST_IDLE;
         default:            state_in = dimp_pkg::ST_CLEAR;
      endcase
      if (clr_start) state_in = dimp_pkg::ST_CLEAR;
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      mem_we     = 1'b0;
      div_start  = 1'b0;
      rsp_load   = 1'b0;
      upd_latch  = 1'b0;
      case (state_ff)
         dimp_pkg::ST_CLEAR: mem_we = 1'b1;
         dimp_pkg::ST_IDLE:  req_tready = 1'b1;
         dimp_pkg::ST_EVAL: begin
            rsp_load  = (func_ff == dimp_pkg::FUNC_PREDICT) & out_free;
            upd_latch = add_go;
            div_start = add_go;
         end
         dimp_pkg::ST_WRITE: mem_we = 1'b1;
         default: ;
      endcase
   end

   // deviation update and divider operands
   always_comb begin
      dev      = $signed({1'b0, rating_ff}) - $signed({1'b0, mean_ff});
      sum_wide = {rd_row_ff.sum[SUM_W-1], rd_row_ff.sum} +
                 {{(SUM_W-RAT_W){dev[RAT_W]}}, dev};
      case (sum_wide[SUM_W:SUM_W-1])
         2'b01:   sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
         2'b10:   sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
         default: sum_sat = sum_wide[SUM_W-1:0];
      endcase
      cnt_sat  = (rd_row_ff.count == '1) ? rd_row_ff.count : rd_row_ff.count + 1'b1;
      divisor  = {1'b0, cnt_sat} + DVS_W'(dimp_pkg::PRIOR_COUNT);
      dividend = sum_sat[SUM_W-1] ? (SUM_W'(0) - sum_sat) : sum_sat;
   end

   // predict result
   assign pred_score = (ids_ok_ff && (rd_row_ff.count != '0)) ? rd_row_ff.score : mean_ff;

   // signed quotient plus mean, clamped
   always_comb begin
      q_mag  = {2'b00, div_rsp.quotient};
      q_sgn  = neg_ff ? (S_W'(0) - q_mag) : q_mag;
      s_wide = q_sgn + S_W'(mean_ff);
      if ($signed(s_wide) < $signed(S_W'(dimp_pkg::SCORE_MIN))) begin
         new_score = SC_W'(dimp_pkg::SCORE_MIN);
      end else if ($signed(s_wide) > $signed(S_W'(dimp_pkg::SCORE_MAX))) begin
         new_score = SC_W'(dimp_pkg::SCORE_MAX);
      end else begin
         new_score = s_wide[SC_W-1:0];
      end
   end

   // table write source: clearing sweep or write-back
   always_comb begin
      if (state_ff == dimp_pkg::ST_CLEAR) begin
         mem_waddr = clr_cnt_ff;
         mem_wdata = '0;
      end else begin
         mem_waddr = addr_ff;
         mem_wdata = '{score: new_score, count: cnt_new_ff, sum: sum_new_ff};
      end
   end

   assign clr_cnt_in   = (clr_start || clr_last) ? '0 :
                         ((state_ff == dimp_pkg::ST_CLEAR) ? clr_cnt_ff + 1'b1 : clr_cnt_ff);
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dimp_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         num_users_ff <= '0;
         num_items_ff <= '0;
         mean_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               dimp_pkg::CSR_NUM_USERS:   num_users_ff <= csr_wdata;
               dimp_pkg::CSR_NUM_ITEMS:   num_items_ff <= csr_wdata[dimp_pkg::NUM_ITEMS_W-1:0];
               dimp_pkg::CSR_MEAN_RATING: mean_ff <= csr_wdata[RAT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // request and update payload
   always_ff @(posedge clock) begin
      if (req_acc) begin
         func_ff   <= req_tuser;
         ids_ok_ff <= ids_ok;
         addr_ff   <= item_ext[ADDR_W-1:0];
         rating_ff <= req_rating;
      end
      if (upd_latch) begin
         sum_new_ff <= sum_sat;
         cnt_new_ff <= cnt_sat;
         neg_ff     <= sum_sat[SUM_W-1];
      end
      if (rsp_load) begin
         score_ff <= pred_score;
      end
   end

   // table: one write port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_row_ff <= mem[addr_ff];
   end

   assign div_req.start    = div_start;
   assign div_req.dividend = dividend;
   assign div_req.divisor  = divisor;

   dimp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(dimp_pkg::RSP_DATA_W-SC_W){1'b0}}, score_ff};

   // checks
   `ASSERT_CLK(a_acc_to_read, clock, reset, req_acc |=> (state_ff == dimp_pkg::ST_READ), "transfer not followed by table read")
   `ASSERT_CLK(a_div_done_state, clock, reset, div_rsp.done |-> (state_ff == dimp_pkg::ST_DIV), "divider done outside divide state")
   `ASSERT_CLK(a_mem_we_state, clock, reset, mem_we |-> ((state_ff == dimp_pkg::ST_CLEAR) || (state_ff == dimp_pkg::ST_WRITE)), "table written outside clear or write-back")
   `ASSERT_CLK(a_rsp_from_predict, clock, reset, $rose(rsp_valid_ff) |-> $past((state_ff == dimp_pkg::ST_EVAL) && (func_ff == dimp_pkg::FUNC_PREDICT)), "result raised without a predict")
   `ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> (!rsp_tvalid && !req_tready), "channels active right after reset")

endmodule

`default_nettype wire

// ===== sim/dimp_score_checker.sv =====
// ----------------------------------------------------------------------------
// dimp_score_checker
// Watches the request, response and config ports of the damped item-mean
// predictor, keeps its own copy of the per-item sum/count/score tables and
// compares every returned score with the oldest predicted one.
// ----------------------------------------------------------------------------
module dimp_score_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [dimp_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [dimp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                              req_tvalid,
   input  wire logic                              req_tready,
   // tdata: user_id[19:0], item_id[31:20], rating_value[42:32], zero pad
   input  wire logic [dimp_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: func
   input  wire logic                              req_tuser,
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // tdata: score[10:0], zero pad
   input  wire logic [dimp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output int                                     fail_count,
   output int                                     score_backlog,
   output int                                     scores_seen
);
   import dimp_pkg::*;

   localparam int          TABLE_DEPTH = MAX_ITEMS_DEF;
   localparam int unsigned COUNT_MAX   = (1 << CNT_W) - 1;
   localparam longint      SUM_HI      = 64'sd2147483647;
   localparam longint      SUM_LO      = -64'sd2147483648;
   localparam int          PRINT_CAP   = 50;

   typedef struct {
      logic [SCORE_W-1:0] score;
      logic [USER_W-1:0]  user;
      logic [ITEM_W-1:0]  item;
   } score_expect_type;

   // predicted scores still waiting for their response transfer
   score_expect_type expected_scores[$];

   // mirrored block state
   int                     dev_sum    [TABLE_DEPTH];
   int unsigned            rate_count [TABLE_DEPTH];
   logic [SCORE_W-1:0]     score_tab  [TABLE_DEPTH];
   logic [NUM_USERS_W-1:0] users_lim;
   logic [NUM_ITEMS_W-1:0] items_lim;
   logic [RATING_W-1:0]    mean_r;

   int                     mismatches = 0;
   int                     seen_count = 0;
   score_expect_type       head;
   score_expect_type       pred;
   logic [USER_W-1:0]      req_user;
   logic [ITEM_W-1:0]      req_item;
   logic [RATING_W-1:0]    req_rating;

   task automatic report_mismatch(input string what);
      if (mismatches < PRINT_CAP)
         $display("MISMATCH @%0t: %s", $time, what);
      mismatches++;
   endtask

   function automatic void clear_tables();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         dev_sum[i]    = 0;
         rate_count[i] = 0;
      end
   endfunction

   // ids below the user limit and the (depth-capped) item limit are valid
   function automatic bit ids_ok(input logic [USER_W-1:0] u, input logic [ITEM_W-1:0] it);
      int unsigned lim;
      lim = (items_lim > TABLE_DEPTH) ? TABLE_DEPTH : items_lim;
      return (u < users_lim) && (it < lim);
   endfunction

   // fold one rating into the item's sum and count, then rescore the item
   function automatic void fold_rating(input logic [USER_W-1:0] u,
                                       input logic [ITEM_W-1:0] it,
                                       input logic [RATING_W-1:0] r);
      longint acc;
      longint quo;
      longint scr;
      if (!ids_ok(u, it))
         return;
      acc = longint'(dev_sum[it]) + longint'(r) - longint'(mean_r);
      if (acc > SUM_HI)
         acc = SUM_HI;
      if (acc < SUM_LO)
         acc = SUM_LO;
      dev_sum[it] = int'(acc);
      if (rate_count[it] < COUNT_MAX)
         rate_count[it]++;
      // signed division truncates toward zero
      quo = acc / (longint'(rate_count[it]) + PRIOR_COUNT);
      scr = longint'(mean_r) + quo;
      if (scr < SCORE_MIN)
         scr = SCORE_MIN;
      if (scr > SCORE_MAX)
         scr = SCORE_MAX;
      score_tab[it] = SCORE_W'(scr);
   endfunction

   function automatic logic [SCORE_W-1:0] predict_score(input logic [USER_W-1:0] u,
                                                        input logic [ITEM_W-1:0] it);
      if (!ids_ok(u, it) || rate_count[it] == 0)
         return mean_r;
      return score_tab[it];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         users_lim = '0;
         items_lim = '0;
         mean_r    = '0;
         clear_tables();
         expected_scores.delete();
      end else begin
         // response transfer: compare with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            seen_count++;
            if (expected_scores.size() == 0) begin
               report_mismatch($sformatf("unexpected score %0d",
                                         rsp_tdata[SCORE_W-1:0]));
            end else begin
               head = expected_scores.pop_front();
               if (rsp_tdata[SCORE_W-1:0] !== head.score)
                  report_mismatch($sformatf("score for user %0d item %0d: got %0d, expected %0d",
                                            head.user, head.item,
                                            rsp_tdata[SCORE_W-1:0], head.score));
            end
         end
         // request transfer: update tables or queue a prediction
         if (req_tvalid && req_tready) begin
            req_user   = req_tdata[USER_W-1:0];
            req_item   = req_tdata[USER_W +: ITEM_W];
            req_rating = req_tdata[USER_W+ITEM_W +: RATING_W];
            if (req_tuser == FUNC_ADD) begin
               fold_rating(req_user, req_item, req_rating);
            end else begin
               pred.score = predict_score(req_user, req_item);
               pred.user  = req_user;
               pred.item  = req_item;
               expected_scores.insert(expected_scores.size(), pred);
            end
         end
         // config writes; item count and mean clear the tables
         if (csr_we) begin
            case (csr_addr)
               CSR_NUM_USERS: begin
                  users_lim = csr_wdata[NUM_USERS_W-1:0];
               end
               CSR_NUM_ITEMS: begin
                  items_lim = csr_wdata[NUM_ITEMS_W-1:0];
                  clear_tables();
               end
               CSR_MEAN_RATING: begin
                  mean_r = csr_wdata[RATING_W-1:0];
                  clear_tables();
               end
               default: ;
            endcase
         end
      end
      fail_count    <= mismatches;
      score_backlog <= expected_scores.size();
      scores_seen   <= seen_count;
   end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the damped item-mean predictor: directed corner
// cases, then randomized rating/predict traffic under several configurations
// with random gaps and stalls on both streams; the checker does the scoring.
// ----------------------------------------------------------------------------
module tb_top;
   import dimp_pkg::*;

   localparam int          USER_SPAN     = 1 << USER_W;
   localparam int          ITEM_SPAN     = MAX_ITEMS_DEF;
   localparam int          SETTLE_CYCLES = 48;
   localparam int          DRAIN_CYCLES  = 60;
   localparam int unsigned RUN_LIMIT     = 2000000;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int                    fail_count;
   int                    score_backlog;
   int                    scores_seen;
   int unsigned           cycle_count = 0;
   int                    calm_left   = 0;
   int                    cfg_users   = 0;
   int                    cfg_items   = 0;

   damped_item_mean_predictor_top #(.MAX_ITEMS(MAX_ITEMS_DEF)) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   dimp_score_checker score_check (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .score_backlog (score_backlog),
      .scores_seen   (scores_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // sender idle gaps: mostly none or short, a few long, some calm stretches
   function automatic int next_gap();
      int roll;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         calm_left = $urandom_range(30, 80);
         return 0;
      end
      if (roll < 55)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 12);
      return $urandom_range(25, 90);
   endfunction

   // one request transfer, then a random gap
   task automatic send_req(input logic fn, input logic [USER_W-1:0] u,
                           input logic [ITEM_W-1:0] it, input logic [RATING_W-1:0] r);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= REQ_DATA_W'({r, it, u});
      do @(posedge clock); while (req_tready !== 1'b1);
      gap = next_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait for all scores and any add in flight, then write all registers
   task automatic reconfigure(input int nu, input int ni, input int gm);
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (score_backlog != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_NUM_USERS;
      csr_wdata <= CSR_DATA_W'(nu);
      @(posedge clock);
      csr_addr  <= CSR_NUM_ITEMS;
      csr_wdata <= CSR_DATA_W'(ni);
      @(posedge clock);
      csr_addr  <= CSR_MEAN_RATING;
      csr_wdata <= CSR_DATA_W'(gm);
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_users = nu;
      cfg_items = ni;
   endtask

   // random traffic: mostly valid ids on a few hot items, some invalid ids
   task automatic random_phase(input int count, input int add_pct);
      int               lim;
      int               ucap;
      int               roll;
      logic             fn;
      logic [USER_W-1:0] u;
      logic [ITEM_W-1:0] it;
      logic [RATING_W-1:0] r;
      lim  = (cfg_items > ITEM_SPAN) ? ITEM_SPAN : cfg_items;
      ucap = (cfg_users > USER_SPAN) ? USER_SPAN : cfg_users;
      for (int n = 0; n < count; n++) begin
         fn = ($urandom_range(0, 99) < add_pct) ? FUNC_ADD : FUNC_PREDICT;
         u  = (ucap > 0) ? USER_W'($urandom_range(0, ucap - 1)) : USER_W'($urandom);
         if (lim > 0) begin
            if ($urandom_range(0, 1) == 0)
               it = ITEM_W'($urandom_range(0, ((lim < 8) ? lim : 8) - 1));
            else
               it = ITEM_W'($urandom_range(0, lim - 1));
         end else begin
            it = ITEM_W'($urandom);
         end
         roll = $urandom_range(0, 99);
         if (roll < 6 && ucap < USER_SPAN)
            u = USER_W'($urandom_range(ucap, USER_SPAN - 1));
         else if (roll < 12 && lim < ITEM_SPAN)
            it = ITEM_W'($urandom_range(lim, ITEM_SPAN - 1));
         if ($urandom_range(0, 4) == 0)
            r = RATING_W'($urandom);
         else
            r = RATING_W'($urandom_range(0, SCORE_MAX));
         send_req(fn, u, it, r);
      end
   endtask

   // receiver: random ready/stall runs plus two long hold-offs
   initial begin
      int span;
      int roll;
      int hold_no;
      hold_no = 0;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_no < 2 && scores_seen >= ((hold_no == 0) ? 40 : 350)) begin
            rsp_tready <= 1'b0;
            span = (hold_no == 0) ? 600 : 250;
            hold_no++;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
               rsp_tready <= 1'b1;
               span = $urandom_range(1, 12);
            end else if (roll < 70) begin
               rsp_tready <= 1'b1;
               span = $urandom_range(100, 300);
            end else if (roll < 95) begin
               rsp_tready <= 1'b0;
               span = $urandom_range(1, 4);
            end else begin
               rsp_tready <= 1'b0;
               span = $urandom_range(20, 70);
            end
         end
         repeat (span) @(posedge clock);
      end
   end

   // main stimulus
   initial begin
      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_addr   <= CSR_NUM_USERS;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= FUNC_ADD;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // item limit above table depth, mean above nominal range
      reconfigure(1000, 8191, 2047);
      send_req(FUNC_PREDICT, 0, 0, 0);          // no ratings: raw mean
      send_req(FUNC_ADD, 0, 0, 0);              // score clamps high
      send_req(FUNC_PREDICT, 0, 0, 0);
      send_req(FUNC_ADD, 999, 4095, 2047);      // top ids, max rating
      send_req(FUNC_PREDICT, 999, 4095, 0);
      send_req(FUNC_ADD, 1000, 7, 2047);        // bad user: ignored
      send_req(FUNC_PREDICT, 1000, 7, 0);
      send_req(FUNC_PREDICT, 0, 7, 2047);
      send_req(FUNC_PREDICT, 1048575, 4095, 0);

      // full user range, zero mean
      reconfigure(USER_SPAN, ITEM_SPAN, 0);
      send_req(FUNC_ADD, 1048575, 4095, 0);     // score clamps low
      send_req(FUNC_PREDICT, 1048575, 4095, 0);
      send_req(FUNC_ADD, 0, 0, 2047);
      send_req(FUNC_ADD, 0, 0, 1280);
      send_req(FUNC_PREDICT, 0, 0, 0);

      // tiny tables, negative deviations truncate toward zero
      reconfigure(5, 3, 1280);
      send_req(FUNC_ADD, 2, 3, 0);              // bad item: ignored
      send_req(FUNC_PREDICT, 2, 3, 0);
      send_req(FUNC_ADD, 5, 1, 0);              // bad user: ignored
      send_req(FUNC_ADD, 4, 2, 0);
      send_req(FUNC_PREDICT, 4, 2, 0);
      send_req(FUNC_ADD, 4, 2, 1280);
      send_req(FUNC_PREDICT, 4, 2, 0);

      // nothing valid
      reconfigure(0, 0, 640);
      send_req(FUNC_ADD, 0, 0, 640);
      send_req(FUNC_PREDICT, 0, 0, 0);

      // random traffic over several configurations
      reconfigure(USER_SPAN, ITEM_SPAN, 896);
      random_phase(300, 50);
      reconfigure(37, 16, $urandom_range(0, 2047));
      random_phase(300, 65);
      reconfigure($urandom_range(1, USER_SPAN), $urandom_range(ITEM_SPAN + 1, 8191), 1280);
      random_phase(250, 50);
      reconfigure(2097151, 1, 0);
      random_phase(150, 60);
      reconfigure($urandom_range(0, USER_SPAN), $urandom_range(0, ITEM_SPAN),
                  $urandom_range(0, 2047));
      random_phase(250, 50);
      reconfigure(2000, 3, 2047);
      random_phase(200, 60);

      // drain
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (score_backlog != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dimp_pkg.sv
rtl/dimp_div.sv
rtl/damped_item_mean_predictor_top.sv
sim/dimp_score_checker.sv
sim/tb_top.sv
